// ----- rtl/upc_pkg.sv -----
package upc_pkg;

  localparam int MAX_ROWS_DEF   = 64;
  localparam int MAX_COLS_DEF   = 16;
  localparam int LEVEL_BITS_DEF = 6;

  localparam int LEVEL_W    = 6;
  localparam int ROWS_CFG_W = 7;
  localparam int COLS_CFG_W = 5;
  localparam int MANT_W     = 32;
  localparam int SHIFT_W    = 6;
  localparam int OFFSET_W   = 47;
  localparam int CFG_W      = 47;
  localparam int CFG_IDX_W  = 3;
  localparam int PAIR_W     = 32;
  localparam int TSQ_W      = 38;
  localparam int CRIT_W     = 64;
  localparam int RT_W       = 16;

  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 7'd8;
  localparam logic [COLS_CFG_W-1:0] COLS_RESET = 5'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_ROWS  = 3'd0,
    CFG_NUM_COLS  = 3'd1,
    CFG_MANTISSA  = 3'd2,
    CFG_SHIFT     = 3'd3,
    CFG_OFFSET    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic store_wr;
    logic eval_init;
    logic row_rd;
    logic row_ld;
    logic pair_init;
    logic col_acc;
    logic pair_upd;
    logic pair_sq;
    logic row_fin;
    logic row_acc;
    logic out_load;
  } upc_cmd_t;

  typedef struct packed {
    logic complete;
    logic first_row;
    logic last_row;
    logic last_pair;
    logic last_col;
    logic out_busy;
  } upc_sts_t;

endpackage

// ----- rtl/upc_if.sv -----
interface upc_in_if;
  logic                        valid;
  logic                        ready;
  logic [upc_pkg::LEVEL_W-1:0] level;

  modport source (output valid, output level, input ready);
  modport sink (input valid, input level, output ready);
endinterface

interface upc_out_if;
  logic                       valid;
  logic                       ready;
  logic [upc_pkg::PAIR_W-1:0] pair_dist_sq_sum;
  logic [upc_pkg::TSQ_W-1:0]  row_total_sq_sum;
  logic signed [upc_pkg::CRIT_W-1:0] criterion_q;

  modport source (output valid, output pair_dist_sq_sum, output row_total_sq_sum,
                  output criterion_q, input ready);
  modport sink (input valid, input pair_dist_sq_sum, input row_total_sq_sum,
                input criterion_q, output ready);
endinterface

// ----- rtl/upc_ram.sv -----
module upc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ----- rtl/upc_ctrl.sv -----
module upc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  upc_pkg::upc_sts_t sts_i,
  output upc_pkg::upc_cmd_t cmd_o
);

  typedef enum logic [16:0] {
    S_LOAD      = 17'h00001,
    S_ROW_RD    = 17'h00002,
    S_ROW_LD    = 17'h00004,
    S_PAIR_INIT = 17'h00008,
    S_COL_RD    = 17'h00010,
    S_COL_ACC   = 17'h00020,
    S_PAIR_RD   = 17'h00040,
    S_PAIR_UPD  = 17'h00080,
    S_PAIR_SQ   = 17'h00100,
    S_ROW_FIN   = 17'h00200,
    S_ROW_ACC   = 17'h00400,
    S_CRIT1     = 17'h00800,
    S_CRIT2     = 17'h01000,
    S_CRIT3     = 17'h02000,
    S_CRIT4     = 17'h04000,
    S_CRIT5     = 17'h08000,
    S_DONE      = 17'h10000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.store_wr = 1'b1;
          if (sts_i.complete) begin
            cmd_o.eval_init = 1'b1;
            state_d = S_ROW_RD;
          end
        end
      end
      S_ROW_RD: begin
        cmd_o.row_rd = 1'b1;
        state_d = S_ROW_LD;
      end
      S_ROW_LD: begin
        cmd_o.row_ld = 1'b1;
        state_d = sts_i.last_row ? S_ROW_FIN : S_PAIR_INIT;
      end
      S_PAIR_INIT: begin
        cmd_o.pair_init = 1'b1;
        state_d = S_COL_RD;
      end
      S_COL_RD: begin
        state_d = S_COL_ACC;
      end
      S_COL_ACC: begin
        cmd_o.col_acc = 1'b1;
        state_d = sts_i.last_col ? S_PAIR_RD : S_COL_RD;
      end
      S_PAIR_RD: begin
        state_d = S_PAIR_UPD;
      end
      S_PAIR_UPD: begin
        cmd_o.pair_upd = 1'b1;
        state_d = S_PAIR_SQ;
      end
      S_PAIR_SQ: begin
        cmd_o.pair_sq = 1'b1;
        state_d = sts_i.last_pair ? S_ROW_FIN : S_PAIR_INIT;
      end
      S_ROW_FIN: begin
        cmd_o.row_fin = 1'b1;
        state_d = S_ROW_ACC;
      end
      S_ROW_ACC: begin
        cmd_o.row_acc = 1'b1;
        state_d = sts_i.last_row ? S_CRIT1 : S_ROW_RD;
      end
      S_CRIT1: state_d = S_CRIT2;
      S_CRIT2: state_d = S_CRIT3;
      S_CRIT3: state_d = S_CRIT4;
      S_CRIT4: state_d = S_CRIT5;
      S_CRIT5: state_d = S_DONE;
      S_DONE: begin
        // hold until the previous word has gone
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

endmodule

// ----- rtl/upc_dp.sv -----
module upc_dp #(
  parameter int MAX_ROWS   = upc_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = upc_pkg::MAX_COLS_DEF,
  parameter int LEVEL_BITS = upc_pkg::LEVEL_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [upc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [upc_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic [upc_pkg::LEVEL_W-1:0]   level_i,
  input  upc_pkg::upc_cmd_t             cmd_i,
  output upc_pkg::upc_sts_t             sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [upc_pkg::PAIR_W-1:0]    pair_o,
  output logic [upc_pkg::TSQ_W-1:0]     tsq_o,
  output logic [upc_pkg::CRIT_W-1:0]    crit_o
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int RC_W  = $clog2(MAX_ROWS + 1);
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int CC_W  = $clog2(MAX_COLS + 1);
  localparam int DW    = $clog2(MAX_COLS * ((1 << LEVEL_BITS) - 1) + 1);
  localparam int NP_W  = upc_pkg::PAIR_W + RC_W;
  localparam int A_W   = (NP_W > upc_pkg::TSQ_W) ? NP_W : upc_pkg::TSQ_W;
  localparam int P_W   = A_W + 32;
  localparam int CRIT_TOP_W = P_W + 2 - (upc_pkg::CRIT_W - 1);

  // configuration
  logic [upc_pkg::ROWS_CFG_W-1:0] num_rows_q;
  logic [upc_pkg::COLS_CFG_W-1:0] num_cols_q;
  logic [upc_pkg::MANT_W-1:0]     mant_q;
  logic [upc_pkg::SHIFT_W-1:0]    shift_q;
  logic [upc_pkg::OFFSET_W-1:0]   offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= upc_pkg::ROWS_RESET;
      num_cols_q <= upc_pkg::COLS_RESET;
      mant_q     <= '0;
      shift_q    <= '0;
      offset_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        upc_pkg::CFG_NUM_ROWS: num_rows_q <= cfg_wdata_i[upc_pkg::ROWS_CFG_W-1:0];
        upc_pkg::CFG_NUM_COLS: num_cols_q <= cfg_wdata_i[upc_pkg::COLS_CFG_W-1:0];
        upc_pkg::CFG_MANTISSA: mant_q     <= cfg_wdata_i[upc_pkg::MANT_W-1:0];
        upc_pkg::CFG_SHIFT:    shift_q    <= cfg_wdata_i[upc_pkg::SHIFT_W-1:0];
        upc_pkg::CFG_OFFSET:   offset_q   <= cfg_wdata_i[upc_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped counts
  logic [RC_W-1:0] rows;
  logic [CC_W-1:0] cols;
  logic [AW:0]     total;

  always_comb begin
    if (32'(num_rows_q) < 32'd2) begin
      rows = RC_W'(2);
    end else if (32'(num_rows_q) > 32'(MAX_ROWS)) begin
      rows = RC_W'(MAX_ROWS);
    end else begin
      rows = RC_W'(num_rows_q);
    end
    if (32'(num_cols_q) < 32'd2) begin
      cols = CC_W'(2);
    end else if (32'(num_cols_q) > 32'(MAX_COLS)) begin
      cols = CC_W'(MAX_COLS);
    end else begin
      cols = CC_W'(num_cols_q);
    end
    total = (AW+1)'(rows) * (AW+1)'(cols);
  end

  // loop state
  logic [AW-1:0]           count_q;
  logic [ROW_W-1:0]        i_q, j_q;
  logic [COL_W-1:0]        k_q;
  logic [AW-1:0]           ax_q, ay_q;
  logic [DW-1:0]           d_q;
  logic [upc_pkg::RT_W-1:0] acc_i_q;
  logic [2*DW-1:0]         dsq_q;
  logic [2*upc_pkg::RT_W-1:0] tsq_term_q;
  logic [upc_pkg::PAIR_W-1:0] pair_q;
  logic [upc_pkg::TSQ_W-1:0]  tsq_q;

  logic [LEVEL_BITS-1:0]   x_rd, y_rd;
  logic [upc_pkg::RT_W-1:0] rt_rd, rt_new;
  logic [LEVEL_BITS+upc_pkg::LEVEL_W-1:0] lvl_ext;
  logic [DW-1:0]           absdiff;
  logic [AW:0]             count_inc;

  assign lvl_ext   = {{LEVEL_BITS{1'b0}}, level_i};
  assign count_inc = (AW+1)'(count_q) + (AW+1)'(1);
  assign absdiff   = (x_rd >= y_rd) ? DW'(x_rd - y_rd) : DW'(y_rd - x_rd);
  assign rt_new    = (i_q == '0 ? '0 : rt_rd) + upc_pkg::RT_W'(d_q);

  assign sts_o.complete  = (count_inc >= total);
  assign sts_o.first_row = (i_q == '0);
  assign sts_o.last_row  = (RC_W'(i_q) == rows - RC_W'(1));
  assign sts_o.last_pair = (RC_W'(j_q) == rows - RC_W'(1));
  assign sts_o.last_col  = (CC_W'(k_q) == cols - CC_W'(1));
  assign sts_o.out_busy  = out_valid_o;

  upc_ram #(.WIDTH(LEVEL_BITS), .DEPTH(DEPTH)) u_store (
    .clk_i     (clk_i),
    .we_i      (cmd_i.store_wr),
    .waddr_i   (count_q),
    .wdata_i   (lvl_ext[LEVEL_BITS-1:0]),
    .raddr_a_i (ax_q),
    .raddr_b_i (ay_q),
    .rdata_a_o (x_rd),
    .rdata_b_o (y_rd)
  );

  logic [ROW_W-1:0] rt_raddr;
  assign rt_raddr = cmd_i.row_rd ? i_q : j_q;

  // row totals: row 0 writes each later row fresh, so no clearing is needed
  upc_ram #(.WIDTH(upc_pkg::RT_W), .DEPTH(MAX_ROWS)) u_rowtot (
    .clk_i     (clk_i),
    .we_i      (cmd_i.pair_upd),
    .waddr_i   (j_q),
    .wdata_i   (rt_new),
    .raddr_a_i (rt_raddr),
    .raddr_b_i (rt_raddr),
    .rdata_a_o (rt_rd),
    .rdata_b_o ()
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      pair_q  <= '0;
      tsq_q   <= '0;
    end else begin
      if (cmd_i.store_wr) begin
        count_q <= sts_o.complete ? '0 : count_inc[AW-1:0];
      end
      if (cmd_i.eval_init) begin
        i_q    <= '0;
        pair_q <= '0;
        tsq_q  <= '0;
      end
      if (cmd_i.row_ld) begin
        j_q <= ROW_W'(RC_W'(i_q) + RC_W'(1));
      end
      if (cmd_i.pair_init) begin
        k_q <= '0;
      end
      if (cmd_i.col_acc) begin
        k_q <= k_q + COL_W'(1);
      end
      if (cmd_i.pair_sq) begin
        pair_q <= pair_q + upc_pkg::PAIR_W'(dsq_q);
        j_q    <= j_q + ROW_W'(1);
      end
      if (cmd_i.row_acc) begin
        tsq_q <= tsq_q + upc_pkg::TSQ_W'(tsq_term_q);
        i_q   <= i_q + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.row_ld) begin
      acc_i_q <= (i_q == '0) ? '0 : rt_rd;
    end
    if (cmd_i.pair_init) begin
      d_q  <= '0;
      ax_q <= AW'(i_q);
      ay_q <= AW'(j_q);
    end
    if (cmd_i.col_acc) begin
      d_q  <= d_q + absdiff;
      ax_q <= ax_q + AW'(rows);
      ay_q <= ay_q + AW'(rows);
    end
    if (cmd_i.pair_upd) begin
      acc_i_q <= acc_i_q + upc_pkg::RT_W'(d_q);
      dsq_q   <= d_q * d_q;
    end
    if (cmd_i.row_fin) begin
      tsq_term_q <= acc_i_q * acc_i_q;
    end
  end

  // criterion pipeline, free running on the settled sums
  logic [NP_W-1:0]       np_q;
  logic [A_W-1:0]        a_q, np_ext, t_ext;
  logic                  neg_q, neg_m_q;
  logic [63:0]           pl_q;
  logic [A_W-1:0]        ph_q;
  logic [P_W-1:0]        prod;
  logic signed [P_W:0]   sv, shv, sh_q;
  logic [P_W+1:0]        sum;
  logic [CRIT_TOP_W-1:0] top_bits;
  logic [upc_pkg::CRIT_W-1:0] res, res_q;

  assign np_ext = A_W'(np_q);
  assign t_ext  = A_W'(tsq_q);
  assign prod   = P_W'(pl_q) + {ph_q, 32'b0};
  assign sv     = neg_m_q ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
  assign shv    = sv >>> shift_q;
  assign sum    = {sh_q[P_W], sh_q} + (P_W+2)'(offset_q);
  assign top_bits = sum[P_W+1:upc_pkg::CRIT_W-1];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      res = sum[upc_pkg::CRIT_W-1:0];
    end else if (sum[P_W+1]) begin
      res = {1'b1, {(upc_pkg::CRIT_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(upc_pkg::CRIT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    np_q    <= NP_W'(rows) * NP_W'(pair_q);
    neg_q   <= (np_ext < t_ext);
    a_q     <= (np_ext < t_ext) ? (t_ext - np_ext) : (np_ext - t_ext);
    pl_q    <= a_q[31:0] * mant_q;
    ph_q    <= A_W'(a_q[A_W-1:32]) * A_W'(mant_q);
    neg_m_q <= neg_q;
    sh_q    <= shv;
    res_q   <= res;
  end

  // output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pair_o <= pair_q;
      tsq_o  <= tsq_q;
      crit_o <= res_q;
    end
  end

endmodule

// ----- rtl/uniform_projection_criterion.sv -----
// Loading: one word per cycle; the word that completes the design starts evaluation.
// Evaluation: R rows, C columns and P = R*(R-1)/2 row pairs are walked in turn, with
// one store read pair per column step and a read-modify-write per row pair.
// No word is taken during evaluation; the result sits in an output register.
// Reset (asynchronous, active low) restores the default counts and clears the count.
module uniform_projection_criterion #(
  parameter int MAX_ROWS   = upc_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = upc_pkg::MAX_COLS_DEF,
  parameter int LEVEL_BITS = upc_pkg::LEVEL_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [upc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [upc_pkg::CFG_W-1:0]     cfg_wdata_i,
  upc_in_if.sink                        in_ch,
  upc_out_if.source                     out_ch
);

  upc_pkg::upc_cmd_t cmd;
  upc_pkg::upc_sts_t sts;
  logic [upc_pkg::CRIT_W-1:0] crit;

  upc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  upc_dp #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .LEVEL_BITS (LEVEL_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .level_i     (in_ch.level),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .pair_o      (out_ch.pair_dist_sq_sum),
    .tsq_o       (out_ch.row_total_sq_sum),
    .crit_o      (crit)
  );

  assign out_ch.criterion_q = $signed(crit);

endmodule
